### rtl/ads_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ads_pkg;

  localparam int CONDUCTANCE_FRAC_BITS = 16;
  localparam int STEP_FRAC_BITS        = 16;
  localparam int COND_W  = CONDUCTANCE_FRAC_BITS + 1;
  localparam int DIFF_W  = 9;
  localparam int PROD_W  = COND_W + 1 + DIFF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int STEP_W  = 15;
  localparam int SCL_W   = STEP_W + 1 + SUM_W;
  localparam int SHIFT   = STEP_FRAC_BITS + CONDUCTANCE_FRAC_BITS;
  localparam int TOT_W   = SCL_W + 1;
  localparam int ROM_N   = 256;
  localparam int BIG_W   = 8 * 9 + 5 * (CONDUCTANCE_FRAC_BITS + 2) + 10;

  localparam logic [STEP_W-1:0] TIME_STEP_RESET = 15'd10923;

  // flux directions
  localparam int DIR_E = 0;
  localparam int DIR_W = 1;
  localparam int DIR_S = 2;
  localparam int DIR_N = 3;

  typedef struct packed {
    logic [7:0] center;
    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] upper;
    logic [7:0] lower;
    logic       region;
  } ads_pix_t;

  typedef struct packed {
    logic [7:0]             center;
    logic                   region;
    logic [3:0][DIFF_W-1:0] diff;
  } ads_diff_t;

  typedef struct packed {
    logic [7:0]             center;
    logic                   region;
    logic [3:0][DIFF_W-1:0] diff;
    logic [3:0][COND_W-1:0] cond;
  } ads_cond_t;

  typedef struct packed {
    logic [7:0]       center;
    logic             region;
    logic [SUM_W-1:0] sum;
  } ads_sum_t;

  // true when 2^F / (1 + (d/2)^1.8) >= k - 1/2
  function automatic logic reaches(int unsigned d, int unsigned k);
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] b;
    logic [BIG_W-1:0] a;
    lhs = BIG_W'(1);
    rhs = BIG_W'(512);
    b   = BIG_W'(2 * k - 1);
    a   = BIG_W'((64'd1 << (CONDUCTANCE_FRAC_BITS + 1)) - 64'(2 * k - 1));
    for (int i = 0; i < 9; i++) begin
      lhs = lhs * BIG_W'(d);
    end
    for (int i = 0; i < 5; i++) begin
      lhs = lhs * b;
      rhs = rhs * a;
    end
    return lhs <= rhs;
  endfunction

  function automatic logic [ROM_N*COND_W-1:0] build_rom();
    logic [ROM_N*COND_W-1:0] rom;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    rom = '0;
    for (int unsigned d = 0; d < ROM_N; d++) begin
      lo = 0;
      hi = 1 << CONDUCTANCE_FRAC_BITS;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (reaches(d, mid)) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      rom[d*COND_W +: COND_W] = COND_W'(lo);
    end
    return rom;
  endfunction

  localparam logic [ROM_N*COND_W-1:0] COND_ROM = build_rom();

  function automatic logic [COND_W-1:0] cond_lookup(logic [7:0] mag);
    return COND_ROM[mag*COND_W +: COND_W];
  endfunction

endpackage

`default_nettype wire

### rtl/ads_grad.sv
`timescale 1ns / 1ps
`default_nettype none

module ads_grad (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ads_pkg::ads_pix_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ads_pkg::ads_cond_t     out_data_o
);

  logic               a_valid_q, b_valid_q;
  logic               a_ready, b_ready;
  ads_pkg::ads_diff_t a_d, a_q;
  ads_pkg::ads_cond_t b_d, b_q;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    a_d.center = in_data_i.center;
    a_d.region = in_data_i.region;
    a_d.diff[ads_pkg::DIR_E] = {1'b0, in_data_i.right}  - {1'b0, in_data_i.center};
    a_d.diff[ads_pkg::DIR_W] = {1'b0, in_data_i.center} - {1'b0, in_data_i.left};
    a_d.diff[ads_pkg::DIR_S] = {1'b0, in_data_i.lower}  - {1'b0, in_data_i.center};
    a_d.diff[ads_pkg::DIR_N] = {1'b0, in_data_i.center} - {1'b0, in_data_i.upper};
  end

  always_comb begin
    logic [ads_pkg::DIFF_W-1:0] mag;
    b_d.center = a_q.center;
    b_d.region = a_q.region;
    b_d.diff   = a_q.diff;
    for (int i = 0; i < 4; i++) begin
      mag = a_q.diff[i][ads_pkg::DIFF_W-1] ? (~a_q.diff[i] + 1'b1) : a_q.diff[i];
      b_d.cond[i] = ads_pkg::cond_lookup(mag[7:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) a_q <= a_d;
    if (b_ready && a_valid_q)  b_q <= b_d;
  end

  assign out_valid_o = b_valid_q;
  assign out_data_o  = b_q;

endmodule

`default_nettype wire

### rtl/ads_flux.sv
`timescale 1ns / 1ps
`default_nettype none

module ads_flux (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ads_pkg::ads_cond_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ads_pkg::ads_sum_t       out_data_o
);

  logic                                c_valid_q, d_valid_q;
  logic                                c_ready, d_ready;
  logic [7:0]                          c_center_q;
  logic                                c_region_q;
  logic [3:0][ads_pkg::PROD_W-1:0]     prod_d, prod_q;
  ads_pkg::ads_sum_t                   s_d, s_q;

  assign d_ready    = !d_valid_q || out_ready_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign in_ready_o = c_ready;

  // flux products, west and north enter with negative sign
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = $signed({1'b0, in_data_i.cond[i]}) * $signed(in_data_i.diff[i]);
    end
  end

  always_comb begin
    s_d.center = c_center_q;
    s_d.region = c_region_q;
    s_d.sum    = ads_pkg::SUM_W'($signed(prod_q[ads_pkg::DIR_E]))
               - ads_pkg::SUM_W'($signed(prod_q[ads_pkg::DIR_W]))
               + ads_pkg::SUM_W'($signed(prod_q[ads_pkg::DIR_S]))
               - ads_pkg::SUM_W'($signed(prod_q[ads_pkg::DIR_N]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) c_valid_q <= in_valid_i;
      if (d_ready) d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_center_q <= in_data_i.center;
      c_region_q <= in_data_i.region;
      prod_q     <= prod_d;
    end
    if (d_ready && c_valid_q) s_q <= s_d;
  end

  assign out_valid_o = d_valid_q;
  assign out_data_o  = s_q;

endmodule

`default_nettype wire

### rtl/ads_update.sv
`timescale 1ns / 1ps
`default_nettype none

module ads_update (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [ads_pkg::STEP_W-1:0] time_step_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire ads_pkg::ads_sum_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [7:0]                      new_pixel_o
);

  logic                       e_valid_q, f_valid_q;
  logic                       e_ready, f_ready;
  logic [7:0]                 e_center_q;
  logic                       e_region_q;
  logic [ads_pkg::SCL_W-1:0]  scl_d, scl_q;
  logic [ads_pkg::TOT_W-1:0]  total;
  logic [ads_pkg::TOT_W-1:0]  quot;
  logic [7:0]                 pix_d, pix_q;

  assign f_ready    = !f_valid_q || out_ready_i;
  assign e_ready    = !e_valid_q || f_ready;
  assign in_ready_o = e_ready;

  assign scl_d = $signed({1'b0, time_step_i}) * $signed(in_data_i.sum);

  always_comb begin
    total = {{(ads_pkg::TOT_W - 8 - ads_pkg::SHIFT){1'b0}}, e_center_q,
             {ads_pkg::SHIFT{1'b0}}}
          + ads_pkg::TOT_W'($signed(scl_q));
    quot  = total >> ads_pkg::SHIFT;
    if (!e_region_q) begin
      pix_d = e_center_q;
    end else if (total[ads_pkg::TOT_W-1]) begin
      pix_d = 8'd0;
    end else if (quot > ads_pkg::TOT_W'(255)) begin
      pix_d = 8'd255;
    end else begin
      pix_d = quot[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      if (e_ready) e_valid_q <= in_valid_i;
      if (f_ready) f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_ready && in_valid_i) begin
      e_center_q <= in_data_i.center;
      e_region_q <= in_data_i.region;
      scl_q      <= scl_d;
    end
    if (f_ready && e_valid_q) pix_q <= pix_d;
  end

  assign out_valid_o = f_valid_q;
  assign new_pixel_o = pix_q;

endmodule

`default_nettype wire

### rtl/anisotropic_diffusion_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One Perona-Malik diffusion update per 8-bit gray pixel from a 4-neighbor stencil.
// Input channel: in_valid_i / in_stall_o with the five pixels and in_region_i;
//   a transfer happens at a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with new_pixel_o, driven from a register.
// Config channel: cfg_valid_i / cfg_ready_o carries the Q0.16 time step; ready is
//   always high, write only while no pixel is in flight.
// Throughput: one pixel per clock unless stalled. Six register stages (differences,
//   conductance ROM, flux products, flux sum, time-step multiply, saturate and
//   output); the transfer edge loads the first stage, and the result is offered
//   from the last stage, the output register.
// Stall: each stage holds while the next one is full and blocked; empty stages
//   keep filling, so in_stall_o rises only once the whole pipe is full behind a
//   stalled output. Nothing is dropped or repeated.
// Reset: all stage valid bits clear, the time step returns to one sixth (10923).
// Pixels outside the region pass through the same pipe with their center value.
module anisotropic_diffusion_step (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [ads_pkg::STEP_W-1:0] time_step_q16_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 center_pixel_i,
  input  wire logic [7:0]                 left_pixel_i,
  input  wire logic [7:0]                 right_pixel_i,
  input  wire logic [7:0]                 upper_pixel_i,
  input  wire logic [7:0]                 lower_pixel_i,
  input  wire logic                       in_region_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [7:0]                      new_pixel_o
);

  logic [ads_pkg::STEP_W-1:0] time_step_q, time_step_d;
  ads_pkg::ads_pix_t          pix;
  ads_pkg::ads_cond_t         cond;
  ads_pkg::ads_sum_t          sum;
  logic                       in_ready;
  logic                       cond_valid, cond_ready;
  logic                       sum_valid, sum_ready;

  assign cfg_ready_o = 1'b1;
  assign time_step_d = (cfg_valid_i && cfg_ready_o) ? time_step_q16_i : time_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= ads_pkg::TIME_STEP_RESET;
    end else begin
      time_step_q <= time_step_d;
    end
  end

  assign pix.center = center_pixel_i;
  assign pix.left   = left_pixel_i;
  assign pix.right  = right_pixel_i;
  assign pix.upper  = upper_pixel_i;
  assign pix.lower  = lower_pixel_i;
  assign pix.region = in_region_i;

  assign in_stall_o = !in_ready;

  ads_grad u_grad (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_data_i   (pix),
    .out_valid_o (cond_valid),
    .out_ready_i (cond_ready),
    .out_data_o  (cond)
  );

  ads_flux u_flux (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cond_valid),
    .in_ready_o  (cond_ready),
    .in_data_i   (cond),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .out_data_o  (sum)
  );

  ads_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .time_step_i (time_step_q),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .in_data_i   (sum),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .new_pixel_o (new_pixel_o)
  );

endmodule

`default_nettype wire

### rtl/ads_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ads_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] new_pixel_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(new_pixel_o))
    else $error("output pixel changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind anisotropic_diffusion_step ads_checker u_ads_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .new_pixel_o (new_pixel_o)
);

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT  = 3000;
  localparam int PIPE_CYCLES = 8;

  logic                       clk_i;
  logic                       rst_ni          = 1'b0;
  logic                       cfg_valid_i     = 1'b0;
  logic                       cfg_ready_o;
  logic [ads_pkg::STEP_W-1:0] time_step_q16_i = '0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic [7:0]                 center_pixel_i  = '0;
  logic [7:0]                 left_pixel_i    = '0;
  logic [7:0]                 right_pixel_i   = '0;
  logic [7:0]                 upper_pixel_i   = '0;
  logic [7:0]                 lower_pixel_i   = '0;
  logic                       in_region_i     = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic [7:0]                 new_pixel_o;

  anisotropic_diffusion_step dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .time_step_q16_i (time_step_q16_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .center_pixel_i  (center_pixel_i),
    .left_pixel_i    (left_pixel_i),
    .right_pixel_i   (right_pixel_i),
    .upper_pixel_i   (upper_pixel_i),
    .lower_pixel_i   (lower_pixel_i),
    .in_region_i     (in_region_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .new_pixel_o     (new_pixel_o)
  );

  int unsigned                conductance [ads_pkg::ROM_N];
  logic [ads_pkg::STEP_W-1:0] step_setting = ads_pkg::TIME_STEP_RESET;
  logic [7:0]                 expected_pixels [$];
  int                         mismatch_count = 0;
  int                         idle_cycles    = 0;
  int                         hold_left      = 0;
  int                         stall_run      = 0;
  bit                         calm           = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // g(d) = round(2^F / (1 + (d/2)^1.8)), exact integer search
  function automatic void fill_conductance();
    logic [199:0] d_pow;
    logic [199:0] lhs;
    logic [199:0] rhs;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    int unsigned  odd;
    for (int d = 0; d < ads_pkg::ROM_N; d++) begin
      d_pow = 200'd1;
      for (int i = 0; i < 9; i++) d_pow = d_pow * 200'(d);
      lo = 0;
      hi = 1 << ads_pkg::CONDUCTANCE_FRAC_BITS;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        odd = 2 * mid - 1;
        lhs = d_pow;
        rhs = 200'd512;
        for (int i = 0; i < 5; i++) begin
          lhs = lhs * 200'(odd);
          rhs = rhs * 200'((1 << (ads_pkg::CONDUCTANCE_FRAC_BITS + 1)) - odd);
        end
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      conductance[d] = lo;
    end
  endfunction

  function automatic longint weighted_flux(int diff);
    int mag;
    mag = (diff < 0) ? -diff : diff;
    return longint'(conductance[mag]) * longint'(diff);
  endfunction

  function automatic logic [7:0] diffuse_pixel(ads_pkg::ads_pix_t px,
                                               logic [ads_pkg::STEP_W-1:0] step);
    longint flux_sum;
    longint total;
    int     c;
    if (!px.region) return px.center;
    c = int'(px.center);
    flux_sum = weighted_flux(int'(px.right) - c) - weighted_flux(c - int'(px.left))
             + weighted_flux(int'(px.lower) - c) - weighted_flux(c - int'(px.upper));
    total = (longint'(c) <<< ads_pkg::SHIFT) + longint'(step) * flux_sum;
    if (total < 0) return 8'd0;
    if ((total >>> ads_pkg::SHIFT) > 255) return 8'd255;
    return 8'(total >>> ads_pkg::SHIFT);
  endfunction

  function automatic ads_pkg::ads_pix_t stencil(int c, int l, int r, int u, int w,
                                                bit reg_bit);
    ads_pkg::ads_pix_t px;
    px.center = 8'(c);
    px.left   = 8'(l);
    px.right  = 8'(r);
    px.upper  = 8'(u);
    px.lower  = 8'(w);
    px.region = reg_bit;
    return px;
  endfunction

  function automatic int clamp_byte(int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  function automatic int near_value(int c, int spread);
    return clamp_byte(c + $urandom_range(0, 2 * spread) - spread);
  endfunction

  function automatic ads_pkg::ads_pix_t random_stencil();
    ads_pkg::ads_pix_t px;
    int                pick;
    int                c;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      c  = $urandom_range(0, 255);
      px = stencil(c, near_value(c, 8), near_value(c, 8), near_value(c, 8),
                   near_value(c, 8), 1'b1);
    end else if (pick < 70) begin
      c  = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4) : $urandom_range(251, 255);
      px = stencil(c, near_value(c, 4), near_value(c, 4), near_value(c, 4),
                   near_value(c, 4), 1'b1);
    end else begin
      px = stencil($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
    end
    px.region = ($urandom_range(0, 99) < 80);
    return px;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_pixel(ads_pkg::ads_pix_t px);
    int gap;
    in_valid_i     <= 1'b1;
    center_pixel_i <= px.center;
    left_pixel_i   <= px.left;
    right_pixel_i  <= px.right;
    upper_pixel_i  <= px.upper;
    lower_pixel_i  <= px.lower;
    in_region_i    <= px.region;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_pixels.push_back(diffuse_pixel(px, step_setting));
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic stop_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_step(logic [ads_pkg::STEP_W-1:0] value);
    wait_drain();
    cfg_valid_i     <= 1'b1;
    time_step_q16_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i  <= 1'b0;
    step_setting  = value;
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_pixel(random_stencil());
    stop_input();
  endtask

  task automatic test_directed_corners();
    send_pixel(stencil(0, 0, 0, 0, 0, 1'b1));
    send_pixel(stencil(255, 255, 255, 255, 255, 1'b1));
    send_pixel(stencil(0, 255, 255, 255, 255, 1'b1));
    send_pixel(stencil(255, 0, 0, 0, 0, 1'b1));
    send_pixel(stencil(128, 126, 130, 127, 129, 1'b1));
    send_pixel(stencil(100, 102, 102, 102, 102, 1'b1));
    send_pixel(stencil(165, 3, 250, 77, 19, 1'b0));
    send_pixel(stencil(0, 255, 255, 255, 255, 1'b0));
    send_pixel(stencil(255, 0, 0, 0, 0, 1'b0));
    stop_input();
    // oversized step: undershoot saturates to zero, overshoot to 255
    write_step(15'h7fff);
    send_pixel(stencil(1, 0, 0, 0, 0, 1'b1));
    send_pixel(stencil(2, 0, 0, 0, 0, 1'b1));
    send_pixel(stencil(253, 255, 255, 255, 255, 1'b1));
    send_pixel(stencil(254, 255, 255, 255, 255, 1'b1));
    send_pixel(stencil(255, 253, 253, 253, 253, 1'b1));
    send_pixel(stencil(3, 1, 5, 0, 7, 1'b1));
    stop_input();
    write_step(15'd0);
    send_pixel(stencil(37, 200, 0, 255, 90, 1'b1));
    send_pixel(stencil(0, 2, 2, 2, 2, 1'b1));
    send_pixel(stencil(255, 253, 253, 253, 253, 1'b1));
    stop_input();
    write_step(15'd16384);
    send_pixel(stencil(253, 255, 255, 255, 255, 1'b1));
    send_pixel(stencil(1, 0, 0, 0, 0, 1'b1));
    send_pixel(stencil(10, 12, 7, 14, 9, 1'b1));
    send_pixel(stencil(200, 180, 220, 199, 201, 1'b1));
    stop_input();
  endtask

  task automatic test_step_sweep();
    logic [ads_pkg::STEP_W-1:0] steps [7];
    steps = '{15'd1, 15'd16384, 15'h7fff, 15'd0, 15'($urandom_range(0, 16384)),
              15'($urandom_range(0, 32767)), ads_pkg::TIME_STEP_RESET};
    for (int p = 0; p < 7; p++) begin
      write_step(steps[p]);
      calm = (p == 2);
      send_random(250);
      calm = 1'b0;
    end
  endtask

  task automatic test_output_backpressure();
    write_step(15'($urandom_range(4096, 16384)));
    calm      = 1'b1;
    hold_left = 300;
    send_random(60);
    calm      = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_random(40);
    wait_drain();
    send_random(40);
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left    = hold_left - 1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run = stall_run - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 35);
      stall_run    = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("new_pixel %0d with no pixel pending", new_pixel_o);
      end else begin
        want = expected_pixels.pop_front();
        if (new_pixel_o !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("new_pixel mismatch: expected %0d, got %0d", want, new_pixel_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    fill_conductance();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_step_sweep();
    test_output_backpressure();
    test_drain_pause();
    wait_drain();
    repeat (2 * PIPE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### anisotropic_diffusion_step.f
rtl/ads_pkg.sv
rtl/ads_grad.sv
rtl/ads_flux.sv
rtl/ads_update.sv
rtl/anisotropic_diffusion_step.sv
rtl/ads_checker.sv
verif/tb.sv
